// ===== design/md5_message_digest_assert.svh =====
// ---------------------------------------------------------------------------
// md5 assertion macros
// concurrent checks, empty bodies when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
`ifndef SYNTH
`define MD5_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 check failed in same cycle");
`define MD5_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 check failed in next cycle");
`else
`define MD5_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MD5_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/md5_pkg.sv =====
// ---------------------------------------------------------------------------
// md5 package
// beat types, round constants and helper functions for the md5 block
// ---------------------------------------------------------------------------
package md5_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS      = 64;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_of_run;
   } rsp_type;

   // index 0 is A
   typedef logic [3:0][31:0] quad_type;

   typedef struct packed {
      logic        final_blk;
      logic [3:0]  words_filled;
      logic        pad_next;
      logic        two_blocks;
      logic [63:0] bit_len;
   } pad_ctx_type;

   localparam quad_type IV = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] K_TAB [ROUNDS] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF,
      32'h4787C62A, 32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF,
      32'hFFFF5BB1, 32'h895CD7BE, 32'h6B901122, 32'hFD987193, 32'hA679438E,
      32'h49B40821, 32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8, 32'h21E1CDE6,
      32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
      32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122,
      32'hFDE5380C, 32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05, 32'hD9D4D039,
      32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665, 32'hF4292244, 32'h432AFF97,
      32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D,
      32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};

   localparam logic [4:0] ROT_TAB [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] idx;
      case (r[5:4])
         2'd0:    idx = r[3:0];
         2'd1:    idx = r[3:0] * 4'd5 + 4'd1;
         2'd2:    idx = r[3:0] * 4'd3 + 4'd5;
         default: idx = r[3:0] * 4'd7;
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      return ROT_TAB[{r[5:4], r[1:0]}];
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      return (x << s) | (x >> (6'd32 - {1'b0, s}));
   endfunction

endpackage

// ===== design/md5_ram.sv =====
// ---------------------------------------------------------------------------
// md5 ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/md5_pad.sv =====
// ---------------------------------------------------------------------------
// md5 pad
// supplies each round's message word, inserting padding and bit length
// ---------------------------------------------------------------------------
module md5_pad (
   input  md5_pkg::pad_ctx_type ctx,
   input  logic                 blk,
   input  logic [3:0]           word_idx,
   input  logic [31:0]          ram_word,
   output logic [31:0]          msg_word
);

   logic [4:0] pos;
   logic [4:0] filled;
   logic [4:0] len_pos;

   assign pos     = {blk, word_idx};
   assign filled  = {1'b0, ctx.words_filled};
   assign len_pos = ctx.two_blocks ? 5'd30 : 5'd14;

   always_comb begin
      if (!ctx.final_blk) begin
         msg_word = ram_word;
      end else if (pos <= filled) begin
         msg_word = ram_word;
      end else if (ctx.pad_next && pos == filled + 5'd1) begin
         msg_word = {24'd0, md5_pkg::PAD_BYTE};
      end else if (pos == len_pos) begin
         msg_word = ctx.bit_len[31:0];
      end else if (pos == len_pos + 5'd1) begin
         msg_word = ctx.bit_len[63:32];
      end else begin
         msg_word = 32'd0;
      end
   end

endmodule

// ===== design/md5_round.sv =====
// ---------------------------------------------------------------------------
// md5 round
// one md5 compression round, reused for all 64 steps of a block
// ---------------------------------------------------------------------------
module md5_round (
   input  md5_pkg::quad_type state_q,
   input  logic [31:0]       msg_word,
   input  logic [5:0]        round_idx,
   output md5_pkg::quad_type state_d
);

   logic [31:0] a, b, c, d;
   logic [31:0] fv;
   logic [31:0] sum;
   logic [31:0] rot;

   assign a = state_q[0];
   assign b = state_q[1];
   assign c = state_q[2];
   assign d = state_q[3];

   always_comb begin
      case (round_idx[5:4])
         2'd0:    fv = (b & c) | (~b & d);
         2'd1:    fv = (b & d) | (c & ~d);
         2'd2:    fv = b ^ c ^ d;
         default: fv = c ^ (b | ~d);
      endcase
   end

   assign sum = a + fv + msg_word + md5_pkg::K_TAB[round_idx];
   assign rot = md5_pkg::rotl32(sum, md5_pkg::rot_amount(round_idx));

   assign state_d[0] = d;
   assign state_d[1] = rot + b;
   assign state_d[2] = b;
   assign state_d[3] = c;

endmodule

// ===== design/md5_message_digest.sv =====
// ---------------------------------------------------------------------------
// md5 message digest
// streaming md5 hash over 32-bit little-endian message words
// ---------------------------------------------------------------------------
// req channel: one message word per beat, first byte in bits 7..0; byte_count
//   matters only on the beat with message_end set (0 to 4 bytes, above 4 = 4).
// rsp channel: four beats per message, digest words A to D, last_of_run on D.
// an ordinary word is taken while idle; the sixteenth word of a block starts a
//   compression (one load, 64 rounds, one fold) during which req_ready is low.
//   the single round unit, reused for every round, limits how fast blocks go.
// the end beat costs one compression, or two when more than 55 bytes are
//   pending, then the four digest beats follow at up to one a cycle.
// rsp_valid stays high while the receiver stalls; no new message word is
//   taken until the fourth digest beat has gone.
// reset restores the initial chaining value and clears the word and byte
//   counts; the block is ready straight out of reset.
// ---------------------------------------------------------------------------
`include "md5_message_digest_assert.svh"

module md5_message_digest (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  md5_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output md5_pkg::rsp_type   rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   md5_pkg::quad_type chain_ff, chain_in;
   md5_pkg::quad_type work_ff, work_in;
   logic [3:0]        wf_ff, wf_in;
   logic [60:0]       len_ff, len_in;
   logic [5:0]        round_ff, round_in;
   logic              blk_ff, blk_in;
   logic              final_ff, final_in;
   logic              pad_next_ff, pad_next_in;
   logic              two_ff, two_in;
   logic [1:0]        idx_ff, idx_in;

   logic              req_acc;
   logic              rsp_acc;
   logic [2:0]        nb_sat;
   logic [31:0]       data_masked;
   logic [31:0]       data_padded;
   logic [6:0]        pend;
   logic [5:0]        round_nxt;
   logic [3:0]        rd_addr;
   logic [31:0]       ram_word;
   logic [31:0]       msg_word;
   md5_pkg::quad_type round_out;
   md5_pkg::pad_ctx_type pad_ctx;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_acc   = rsp_valid && rsp_ready;

   assign nb_sat = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;

   always_comb begin
      case (nb_sat)
         3'd0:    data_masked = 32'd0;
         3'd1:    data_masked = {24'd0, req_data.data_word[7:0]};
         3'd2:    data_masked = {16'd0, req_data.data_word[15:0]};
         3'd3:    data_masked = {8'd0, req_data.data_word[23:0]};
         default: data_masked = req_data.data_word;
      endcase
   end

   assign data_padded = (nb_sat == 3'd4) ? data_masked :
      (data_masked | ({24'd0, md5_pkg::PAD_BYTE} << {nb_sat[1:0], 3'b000}));

   assign pend      = {1'b0, wf_ff, 2'b00} + {4'd0, nb_sat};
   assign round_nxt = round_ff + 6'd1;
   assign rd_addr   = (state_ff == ST_ROUND) ? md5_pkg::msg_index(round_nxt) :
                      md5_pkg::msg_index(6'd0);

   md5_ram #(
      .WIDTH (32),
      .DEPTH (md5_pkg::BLOCK_WORDS)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (wf_ff),
      .wr_data (req_data.message_end ? data_padded : req_data.data_word),
      .rd_addr (rd_addr),
      .rd_data (ram_word)
   );

   assign pad_ctx.final_blk    = final_ff;
   assign pad_ctx.words_filled = wf_ff;
   assign pad_ctx.pad_next     = pad_next_ff;
   assign pad_ctx.two_blocks   = two_ff;
   assign pad_ctx.bit_len      = {len_ff, 3'b000};

   md5_pad u_pad (
      .ctx      (pad_ctx),
      .blk      (blk_ff),
      .word_idx (md5_pkg::msg_index(round_ff)),
      .ram_word (ram_word),
      .msg_word (msg_word)
   );

   md5_round u_round (
      .state_q   (work_ff),
      .msg_word  (msg_word),
      .round_idx (round_ff),
      .state_d   (round_out)
   );

   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      wf_in       = wf_ff;
      len_in      = len_ff;
      round_in    = round_ff;
      blk_in      = blk_ff;
      final_in    = final_ff;
      pad_next_in = pad_next_ff;
      two_in      = two_ff;
      idx_in      = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               blk_in = 1'b0;
               if (req_data.message_end) begin
                  len_in      = len_ff + {58'd0, nb_sat};
                  final_in    = 1'b1;
                  pad_next_in = (nb_sat == 3'd4);
                  two_in      = (pend > 7'd55);
                  state_in    = ST_LOAD;
               end else begin
                  len_in   = len_ff + 61'd4;
                  wf_in    = wf_ff + 4'd1;
                  final_in = 1'b0;
                  if (wf_ff == 4'd15) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            work_in  = chain_ff;
            round_in = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in  = round_out;
            round_in = round_nxt;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int k = 0; k < 4; k++) begin
               chain_in[k] = chain_ff[k] + work_ff[k];
            end
            if (final_ff && two_ff && !blk_ff) begin
               blk_in   = 1'b1;
               state_in = ST_LOAD;
            end else if (final_ff) begin
               idx_in   = 2'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in = md5_pkg::IV;
                  wf_in    = 4'd0;
                  len_in   = 61'd0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= md5_pkg::IV;
         wf_ff    <= 4'd0;
         len_ff   <= 61'd0;
         round_ff <= 6'd0;
         blk_ff   <= 1'b0;
         final_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         wf_ff    <= wf_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         blk_ff   <= blk_in;
         final_ff <= final_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      pad_next_ff <= pad_next_in;
      two_ff      <= two_in;
   end

   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_of_run = (idx_ff == 2'd3);

   // a word and a digest beat never move in the same cycle
   `MD5_ASSERT_SAME(a_no_overlap, clock, reset, req_ready, !rsp_valid)
   // the last round is always followed by the fold
   `MD5_ASSERT_NEXT(a_round_fold, clock, reset,
      (state_ff == ST_ROUND) && (round_ff == 6'd63), state_ff == ST_FOLD)
   // the end beat always starts a compression
   `MD5_ASSERT_NEXT(a_end_load, clock, reset,
      req_acc && req_data.message_end, (state_ff == ST_LOAD) && final_ff)
   // after the final digest beat the chaining value is back at its start value
   `MD5_ASSERT_NEXT(a_iv_back, clock, reset,
      rsp_acc && rsp_data.last_of_run,
      req_ready && (chain_ff == md5_pkg::IV) && (wf_ff == 4'd0))

endmodule
